// File: src/ekdc_pkg.sv
// ----------------------------------------------------------------------------
// ekdc_pkg
// Shared types, byte codes and decode helpers for the escape key decoder.
// ----------------------------------------------------------------------------
package ekdc_pkg;

  localparam int COORD_WIDTH_DEFAULT = 10;
  localparam int SIZE_W              = 10;
  localparam int CFG_IDX_W           = 1;

  localparam logic [SIZE_W-1:0] ROWS_RESET = 10'd24;
  localparam logic [SIZE_W-1:0] COLS_RESET = 10'd80;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 1'd1;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_CSI   = 8'h5b;  // '['
  localparam logic [7:0] CH_SS3   = 8'h4f;  // 'O'
  localparam logic [7:0] CH_TILDE = 8'h7e;  // '~'
  localparam logic [7:0] CH_UP    = 8'h41;  // 'A'
  localparam logic [7:0] CH_DOWN  = 8'h42;  // 'B'
  localparam logic [7:0] CH_RIGHT = 8'h43;  // 'C'
  localparam logic [7:0] CH_LEFT  = 8'h44;  // 'D'
  localparam logic [7:0] CH_HOME  = 8'h48;  // 'H'
  localparam logic [7:0] CH_END   = 8'h46;  // 'F'
  localparam logic [7:0] CH_QUIT  = 8'h11;  // Ctrl-Q
  localparam logic [7:0] CH_DIG1  = 8'h31;  // '1'
  localparam logic [7:0] CH_DIG3  = 8'h33;
  localparam logic [7:0] CH_DIG4  = 8'h34;
  localparam logic [7:0] CH_DIG5  = 8'h35;
  localparam logic [7:0] CH_DIG6  = 8'h36;
  localparam logic [7:0] CH_DIG7  = 8'h37;
  localparam logic [7:0] CH_DIG8  = 8'h38;
  localparam logic [7:0] CH_DIG9  = 8'h39;

  typedef enum logic [3:0] {
    KEY_PLAIN = 4'd0,
    KEY_ESC   = 4'd1,
    KEY_LEFT  = 4'd2,
    KEY_RIGHT = 4'd3,
    KEY_UP    = 4'd4,
    KEY_DOWN  = 4'd5,
    KEY_PGUP  = 4'd6,
    KEY_PGDN  = 4'd7,
    KEY_HOME  = 4'd8,
    KEY_END   = 4'd9,
    KEY_DEL   = 4'd10
  } key_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_ESC1  = 2'd2,
    PH_DIGIT = 2'd3
  } phase_t;

  // Decoded key handed from the parser to the cursor stage
  typedef struct packed {
    logic      has_key;
    key_kind_t kind;
    logic [7:0] kbyte;
    logic      quit;
  } key_t;

  function automatic key_kind_t letter_key(input logic [7:0] b, input logic csi);
    key_kind_t k;
    k = KEY_ESC;
    priority if (b == CH_HOME) k = KEY_HOME;
    else if (b == CH_END) k = KEY_END;
    else if (!csi) k = KEY_ESC;
    else if (b == CH_UP) k = KEY_UP;
    else if (b == CH_DOWN) k = KEY_DOWN;
    else if (b == CH_RIGHT) k = KEY_RIGHT;
    else if (b == CH_LEFT) k = KEY_LEFT;
    else k = KEY_ESC;
    return k;
  endfunction

  function automatic key_kind_t digit_key(input logic [7:0] d);
    key_kind_t k;
    k = KEY_ESC;
    unique case (d)
      CH_DIG1, CH_DIG7: k = KEY_HOME;
      CH_DIG3:          k = KEY_DEL;
      CH_DIG4, CH_DIG8: k = KEY_END;
      CH_DIG5:          k = KEY_PGUP;
      CH_DIG6:          k = KEY_PGDN;
      default:          k = KEY_ESC;
    endcase
    return k;
  endfunction

endpackage

// File: src/ekdc_parser.sv
// ----------------------------------------------------------------------------
// ekdc_parser
// Escape sequence state machine: turns bytes and gap timeouts into keys.
// ----------------------------------------------------------------------------
module ekdc_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,     // consume the presented beat
  input  logic            mode,     // 1 = gap timeout
  input  logic [7:0]      in_byte,
  output ekdc_pkg::key_t  key
);

  ekdc_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] digit_r, digit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ekdc_pkg::PH_IDLE;
      first_r <= 8'd0;
      digit_r <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      digit_r <= digit_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    first_nxt   = first_r;
    digit_nxt   = digit_r;
    key.has_key = 1'b0;
    key.kind    = ekdc_pkg::KEY_ESC;
    key.kbyte   = 8'd0;
    key.quit    = 1'b0;
    if (mode) begin
      // timeout only matters part way through a sequence
      if (phase_r != ekdc_pkg::PH_IDLE) begin
        key.has_key = 1'b1;
        phase_nxt   = ekdc_pkg::PH_IDLE;
      end
    end else begin
      unique case (phase_r)
        ekdc_pkg::PH_IDLE: begin
          if (in_byte == ekdc_pkg::CH_ESC) begin
            phase_nxt = ekdc_pkg::PH_ESC;
          end else begin
            key.has_key = 1'b1;
            key.kind    = ekdc_pkg::KEY_PLAIN;
            key.kbyte   = in_byte;
            key.quit    = (in_byte == ekdc_pkg::CH_QUIT);
          end
        end
        ekdc_pkg::PH_ESC: begin
          first_nxt = in_byte;
          phase_nxt = ekdc_pkg::PH_ESC1;
        end
        ekdc_pkg::PH_ESC1: begin
          if (first_r == ekdc_pkg::CH_CSI && in_byte >= ekdc_pkg::CH_DIG1 &&
              in_byte <= ekdc_pkg::CH_DIG9) begin
            digit_nxt = in_byte;
            phase_nxt = ekdc_pkg::PH_DIGIT;
          end else begin
            phase_nxt   = ekdc_pkg::PH_IDLE;
            key.has_key = 1'b1;
            if (first_r == ekdc_pkg::CH_CSI)
              key.kind = ekdc_pkg::letter_key(in_byte, 1'b1);
            else if (first_r == ekdc_pkg::CH_SS3)
              key.kind = ekdc_pkg::letter_key(in_byte, 1'b0);
            else
              key.kind = ekdc_pkg::KEY_ESC;
          end
        end
        ekdc_pkg::PH_DIGIT: begin
          phase_nxt   = ekdc_pkg::PH_IDLE;
          key.has_key = 1'b1;
          key.kind    = (in_byte == ekdc_pkg::CH_TILDE) ?
                        ekdc_pkg::digit_key(digit_r) : ekdc_pkg::KEY_ESC;
        end
        default: phase_nxt = ekdc_pkg::PH_IDLE;
      endcase
    end
  end

endmodule

// File: src/escape_key_decoder_cursor.sv
// ----------------------------------------------------------------------------
// escape_key_decoder_cursor
// Terminal key decoder with a cursor kept inside the configured screen.
// ----------------------------------------------------------------------------
// One beat is taken per clock cycle while in_stall is low, and a key, if the
// beat completes one, is presented on the result ports after the beat has sat
// in the input register and the decode and cursor logic have loaded the result
// register. A stalled result holds the input off only while the beat in the
// input register would give another key. Bytes that open or continue an
// escape sequence, and gap timeouts while idle, give no result. Screen size
// writes are taken at once (cfg_ready is always high) and should only be made
// while the block is idle.
module escape_key_decoder_cursor #(
  parameter int COORD_WIDTH = ekdc_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_mode,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     out_key_kind,
  output logic [7:0]                     out_key_byte,
  output logic [COORD_WIDTH-1:0]         out_cursor_col,
  output logic [COORD_WIDTH-1:0]         out_cursor_row,
  output logic                           out_quit,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ekdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ekdc_pkg::SIZE_W-1:0]    cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int LW = (CW > ekdc_pkg::SIZE_W) ? CW : ekdc_pkg::SIZE_W;
  localparam logic [LW-1:0] COORD_MAX = LW'((32'd1 << CW) - 32'd1);

  // screen size registers
  logic [ekdc_pkg::SIZE_W-1:0] rows_r, cols_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ekdc_pkg::ROWS_RESET;
      cols_r <= ekdc_pkg::COLS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ekdc_pkg::CFG_SCREEN_ROWS) rows_r <= cfg_data;
      if (cfg_index == ekdc_pkg::CFG_SCREEN_COLS) cols_r <= cfg_data;
    end
  end

  // input register
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic       out_ready;
  logic       advance;
  ekdc_pkg::key_t key;

  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && (!key.has_key || out_ready);
  assign in_stall  = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_byte;
    end
  end

  ekdc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .mode    (s1_mode_r),
    .in_byte (s1_byte_r),
    .key     (key)
  );

  // last valid index: size 0 acts as 1, then capped to the coordinate range
  function automatic logic [CW-1:0] last_index(input logic [ekdc_pkg::SIZE_W-1:0] size);
    logic [ekdc_pkg::SIZE_W-1:0] last;
    logic [LW-1:0] ext;
    last = (size == '0) ? '0 : size - 1'b1;
    ext  = LW'(last);
    return CW'((ext > COORD_MAX) ? COORD_MAX : ext);
  endfunction

  function automatic logic [CW-1:0] step_up(input logic [CW-1:0] v,
                                            input logic [CW-1:0] last);
    logic [CW:0] n;
    n = {1'b0, v} + 1'b1;
    return (n > {1'b0, last}) ? last : CW'(n);
  endfunction

  logic [CW-1:0] last_col, last_row;
  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;

  assign last_col = last_index(cols_r);
  assign last_row = last_index(rows_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    unique case (key.kind)
      ekdc_pkg::KEY_LEFT:  if (col_r != '0) col_nxt = col_r - 1'b1;
      ekdc_pkg::KEY_RIGHT: col_nxt = step_up(col_r, last_col);
      ekdc_pkg::KEY_UP:    if (row_r != '0) row_nxt = row_r - 1'b1;
      ekdc_pkg::KEY_DOWN:  row_nxt = step_up(row_r, last_row);
      ekdc_pkg::KEY_HOME:  col_nxt = '0;
      ekdc_pkg::KEY_END:   col_nxt = last_col;
      ekdc_pkg::KEY_PGUP:  row_nxt = '0;
      ekdc_pkg::KEY_PGDN:  row_nxt = last_row;
      default: ;
    endcase
  end

  // result register
  logic [3:0]    kind_r;
  logic [7:0]    kbyte_r;
  logic          quit_r;
  logic          load;

  assign load = advance && key.has_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      if (out_ready) out_valid_r <= load;
      if (load) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= key.kind;
      kbyte_r <= key.kbyte;
      quit_r  <= key.quit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_kind   = kind_r;
  assign out_key_byte   = kbyte_r;
  assign out_quit       = quit_r;
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;

endmodule

// File: src/ekdc_checker.sv
// ----------------------------------------------------------------------------
// ekdc_checker
// Port-level checks for the escape key decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ekdc_checker #(
  parameter int COORD_WIDTH = ekdc_pkg::COORD_WIDTH_DEFAULT
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [3:0]             out_key_kind,
  input logic [7:0]             out_key_byte,
  input logic [COORD_WIDTH-1:0] out_cursor_col,
  input logic [COORD_WIDTH-1:0] out_cursor_row,
  input logic                   out_quit
);

  // no beat straight out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key_kind) &&
      $stable(out_key_byte) && $stable(out_cursor_col) &&
      $stable(out_cursor_row) && $stable(out_quit))
    else $error("stalled result beat changed");

  a_quit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quit |-> out_key_kind == ekdc_pkg::KEY_PLAIN &&
      out_key_byte == ekdc_pkg::CH_QUIT)
    else $error("quit on a key other than Ctrl-Q");

  a_nonplain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_kind != ekdc_pkg::KEY_PLAIN |-> out_key_byte == 8'd0 &&
      !out_quit)
    else $error("decoded key carries a byte");

  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_key_kind == ekdc_pkg::KEY_HOME ||
                  out_key_kind == ekdc_pkg::KEY_PGUP) |->
      (out_key_kind == ekdc_pkg::KEY_HOME && out_cursor_col == '0) ||
      (out_key_kind == ekdc_pkg::KEY_PGUP && out_cursor_row == '0))
    else $error("home or page up left cursor off the edge");

endmodule

bind escape_key_decoder_cursor ekdc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ekdc_checker (.*);

// File: tb/ekdc_key_checker.sv
// ----------------------------------------------------------------------------
// ekdc_key_checker
// Watches the byte, key and screen size channels of the escape key decoder.
// It keeps its own copy of the parser, the cursor and the screen size and
// works out the key that each accepted byte or timeout beat should give. Each
// key that leaves the block is compared, field by field, with the oldest key
// still owed.
// ----------------------------------------------------------------------------
module ekdc_key_checker #(
  parameter int COORD_WIDTH = ekdc_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_mode,
  input  logic [7:0]                     in_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [3:0]                     out_key_kind,
  input  logic [7:0]                     out_key_byte,
  input  logic [COORD_WIDTH-1:0]         out_cursor_col,
  input  logic [COORD_WIDTH-1:0]         out_cursor_row,
  input  logic                           out_quit,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ekdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ekdc_pkg::SIZE_W-1:0]    cfg_data,
  output int                             n_fail,
  output int                             n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ekdc_pkg::key_kind_t    kind;
    logic [7:0]             kbyte;
    logic [COORD_WIDTH-1:0] col;
    logic [COORD_WIDTH-1:0] row;
    logic                   quit;
  } key_res_t;

  key_res_t                    owed_keys[$];
  ekdc_pkg::phase_t            phase;
  logic [7:0]                  esc_lead;
  logic [7:0]                  csi_digit;
  logic [COORD_WIDTH-1:0]      col;
  logic [COORD_WIDTH-1:0]      row;
  logic [ekdc_pkg::SIZE_W-1:0] rows;
  logic [ekdc_pkg::SIZE_W-1:0] cols;
  int                          fails;

  // Last usable index for a screen size; 0 is taken as 1
  function automatic logic [COORD_WIDTH-1:0] last_of(
    input logic [ekdc_pkg::SIZE_W-1:0] size
  );
    int s;
    int cmax;
    s    = (size == '0) ? 1 : int'(size);
    cmax = (1 << COORD_WIDTH) - 1;
    return (s - 1 > cmax) ? cmax[COORD_WIDTH-1:0] : COORD_WIDTH'(s - 1);
  endfunction

  function automatic ekdc_pkg::key_kind_t letter_kind(input logic [7:0] b,
                                                      input logic csi);
    ekdc_pkg::key_kind_t k;
    k = ekdc_pkg::KEY_ESC;
    if (b == ekdc_pkg::CH_HOME) k = ekdc_pkg::KEY_HOME;
    else if (b == ekdc_pkg::CH_END) k = ekdc_pkg::KEY_END;
    else if (csi) begin
      case (b)
        ekdc_pkg::CH_UP:    k = ekdc_pkg::KEY_UP;
        ekdc_pkg::CH_DOWN:  k = ekdc_pkg::KEY_DOWN;
        ekdc_pkg::CH_RIGHT: k = ekdc_pkg::KEY_RIGHT;
        ekdc_pkg::CH_LEFT:  k = ekdc_pkg::KEY_LEFT;
        default:            k = ekdc_pkg::KEY_ESC;
      endcase
    end
    return k;
  endfunction

  function automatic ekdc_pkg::key_kind_t tilde_kind(input logic [7:0] d);
    ekdc_pkg::key_kind_t k;
    case (d)
      ekdc_pkg::CH_DIG1, ekdc_pkg::CH_DIG7: k = ekdc_pkg::KEY_HOME;
      ekdc_pkg::CH_DIG3:                    k = ekdc_pkg::KEY_DEL;
      ekdc_pkg::CH_DIG4, ekdc_pkg::CH_DIG8: k = ekdc_pkg::KEY_END;
      ekdc_pkg::CH_DIG5:                    k = ekdc_pkg::KEY_PGUP;
      ekdc_pkg::CH_DIG6:                    k = ekdc_pkg::KEY_PGDN;
      default:                              k = ekdc_pkg::KEY_ESC;
    endcase
    return k;
  endfunction

  task automatic decode_beat(input logic mode, input logic [7:0] b);
    ekdc_pkg::key_kind_t    kind;
    logic [7:0]             kb;
    logic                   q;
    logic                   done;
    logic [COORD_WIDTH-1:0] lc;
    logic [COORD_WIDTH-1:0] lr;
    kind = ekdc_pkg::KEY_ESC;
    kb   = '0;
    q    = 1'b0;
    done = 1'b1;
    if (mode) begin
      if (phase == ekdc_pkg::PH_IDLE) done = 1'b0;
      phase = ekdc_pkg::PH_IDLE;
    end else begin
      case (phase)
        ekdc_pkg::PH_IDLE: begin
          if (b == ekdc_pkg::CH_ESC) begin
            phase = ekdc_pkg::PH_ESC;
            done  = 1'b0;
          end else begin
            kind = ekdc_pkg::KEY_PLAIN;
            kb   = b;
            q    = (b == ekdc_pkg::CH_QUIT);
          end
        end
        ekdc_pkg::PH_ESC: begin
          esc_lead = b;
          phase    = ekdc_pkg::PH_ESC1;
          done     = 1'b0;
        end
        ekdc_pkg::PH_ESC1: begin
          if (esc_lead == ekdc_pkg::CH_CSI && b >= ekdc_pkg::CH_DIG1 &&
              b <= ekdc_pkg::CH_DIG9) begin
            csi_digit = b;
            phase     = ekdc_pkg::PH_DIGIT;
            done      = 1'b0;
          end else begin
            phase = ekdc_pkg::PH_IDLE;
            if (esc_lead == ekdc_pkg::CH_CSI) kind = letter_kind(b, 1'b1);
            else if (esc_lead == ekdc_pkg::CH_SS3) kind = letter_kind(b, 1'b0);
          end
        end
        default: begin
          phase = ekdc_pkg::PH_IDLE;
          kind  = (b == ekdc_pkg::CH_TILDE) ? tilde_kind(csi_digit) : ekdc_pkg::KEY_ESC;
        end
      endcase
    end
    if (done) begin
      lc = last_of(cols);
      lr = last_of(rows);
      // beyond the edge after a shrink: steps up clamp, steps down go by one
      case (kind)
        ekdc_pkg::KEY_LEFT:  if (col != '0) col = col - 1'b1;
        ekdc_pkg::KEY_RIGHT: col = (col >= lc) ? lc : col + 1'b1;
        ekdc_pkg::KEY_UP:    if (row != '0) row = row - 1'b1;
        ekdc_pkg::KEY_DOWN:  row = (row >= lr) ? lr : row + 1'b1;
        ekdc_pkg::KEY_HOME:  col = '0;
        ekdc_pkg::KEY_END:   col = lc;
        ekdc_pkg::KEY_PGUP:  row = '0;
        ekdc_pkg::KEY_PGDN:  row = lr;
        default: ;
      endcase
      owed_keys.push_back(key_res_t'{kind, kb, col, row, q});
    end
  endtask

  task automatic check_key();
    key_res_t exp_key;
    if (owed_keys.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected key: kind %0d byte %02h col %0d row %0d quit %0b",
                 out_key_kind, out_key_byte, out_cursor_col, out_cursor_row, out_quit);
    end else begin
      exp_key = owed_keys.pop_front();
      if (out_key_kind !== exp_key.kind || out_key_byte !== exp_key.kbyte ||
          out_cursor_col !== exp_key.col || out_cursor_row !== exp_key.row ||
          out_quit !== exp_key.quit) begin
        fails++;
        if (fails <= 10)
          $display("key mismatch: exp kind %0d byte %02h col %0d row %0d quit %0b",
                   exp_key.kind, exp_key.kbyte, exp_key.col, exp_key.row, exp_key.quit,
                   " / got kind %0d byte %02h col %0d row %0d quit %0b",
                   out_key_kind, out_key_byte, out_cursor_col, out_cursor_row, out_quit);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_keys.delete();
      phase     = ekdc_pkg::PH_IDLE;
      esc_lead  = '0;
      csi_digit = '0;
      col       = '0;
      row       = '0;
      rows      = ekdc_pkg::ROWS_RESET;
      cols      = ekdc_pkg::COLS_RESET;
    end else begin
      if (out_valid && !out_stall) check_key();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ekdc_pkg::CFG_SCREEN_ROWS) rows = cfg_data;
        else if (cfg_index == ekdc_pkg::CFG_SCREEN_COLS) cols = cfg_data;
      end
      if (in_valid && !in_stall) decode_beat(in_mode, in_byte);
    end
    n_pending <= owed_keys.size();
    n_fail    <= fails;
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the escape key decoder with a short directed stream of bytes and
// timeouts, then with random key sequences over a range of screen sizes.
// Both channels idle and stall in random bursts; the checker beside the block
// predicts every key and reports the failures that decide the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = ekdc_pkg::COORD_WIDTH_DEFAULT;
  localparam int PHASE_BEATS = 250;
  localparam int N_PHASES    = 8;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_mode   = 1'b0;
  logic [7:0]                     in_byte   = '0;
  logic                           out_stall = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [ekdc_pkg::CFG_IDX_W-1:0] cfg_index = ekdc_pkg::CFG_SCREEN_ROWS;
  logic [ekdc_pkg::SIZE_W-1:0]    cfg_data  = '0;
  logic                           in_stall;
  logic                           out_valid;
  logic [3:0]                     out_key_kind;
  logic [7:0]                     out_key_byte;
  logic [CW-1:0]                  out_cursor_col;
  logic [CW-1:0]                  out_cursor_row;
  logic                           out_quit;
  logic                           cfg_ready;
  int                             n_fail;
  int                             n_pending;
  logic                           calm      = 1'b0;
  logic                           long_hold = 1'b0;
  logic                           gappy     = 1'b1;
  int                             beats_sent;

  escape_key_decoder_cursor u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_byte,
    .out_valid, .out_stall, .out_key_kind, .out_key_byte,
    .out_cursor_col, .out_cursor_row, .out_quit,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ekdc_key_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_byte,
    .out_valid, .out_stall, .out_key_kind, .out_key_byte,
    .out_cursor_col, .out_cursor_row, .out_quit,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .n_fail, .n_pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Key receiver: random stall bursts, one long hold-off, none when calm
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic mode, input logic [7:0] b);
    if (gappy && !calm && !long_hold && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_esc(input logic [7:0] lead, input logic [7:0] b);
    send_beat(1'b0, ekdc_pkg::CH_ESC);
    send_beat(1'b0, lead);
    send_beat(1'b0, b);
  endtask

  // Drop valid and wait out every owed key plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [ekdc_pkg::SIZE_W-1:0] r,
                             input logic [ekdc_pkg::SIZE_W-1:0] c);
    cfg_valid <= 1'b1;
    cfg_index <= ekdc_pkg::CFG_SCREEN_ROWS;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= ekdc_pkg::CFG_SCREEN_COLS;
    cfg_data  <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ekdc_pkg::SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 10'd1;
      2:       return 10'd1023;
      3:       return 10'd2;
      4:       return ekdc_pkg::SIZE_W'($urandom_range(0, 1023));
      default: return ekdc_pkg::SIZE_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic send_random_key();
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0, 1, 2: send_beat(1'b0, 8'($urandom));
      3:       send_beat(1'b0, ekdc_pkg::CH_QUIT);
      4, 5, 6, 7: begin
        case ($urandom_range(0, 3))
          0:       b = ekdc_pkg::CH_UP;
          1:       b = ekdc_pkg::CH_DOWN;
          2:       b = ekdc_pkg::CH_LEFT;
          default: b = ekdc_pkg::CH_RIGHT;
        endcase
        send_esc(ekdc_pkg::CH_CSI, b);
      end
      8:  send_esc($urandom_range(0, 1) ? ekdc_pkg::CH_CSI : ekdc_pkg::CH_SS3,
                   $urandom_range(0, 1) ? ekdc_pkg::CH_HOME : ekdc_pkg::CH_END);
      9, 10: begin
        // ESC [ 0 and ESC [ digit without the tilde fall back to escape
        send_esc(ekdc_pkg::CH_CSI, 8'($urandom_range(8'h30, 8'h39)));
        send_beat(1'b0, $urandom_range(0, 4) != 0 ? ekdc_pkg::CH_TILDE : 8'($urandom));
      end
      11: send_esc(ekdc_pkg::CH_SS3, 8'($urandom_range(8'h40, 8'h5a)));
      12: send_esc(8'($urandom), 8'($urandom));
      13: begin
        // sequence cut short by a gap timeout
        send_beat(1'b0, ekdc_pkg::CH_ESC);
        if ($urandom_range(0, 1)) begin
          send_beat(1'b0, ekdc_pkg::CH_CSI);
          if ($urandom_range(0, 1)) send_beat(1'b0, 8'($urandom_range(8'h31, 8'h39)));
        end
        send_beat(1'b1, 8'($urandom));
      end
      14: send_beat(1'b1, 8'($urandom));
      default: send_esc(ekdc_pkg::CH_CSI, 8'($urandom));
    endcase
  endtask

  initial begin
    logic [ekdc_pkg::SIZE_W-1:0] r;
    logic [ekdc_pkg::SIZE_W-1:0] c;
    int                          start;
    beats_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset screen size
    send_beat(1'b1, 8'h00);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hff);
    send_beat(1'b0, ekdc_pkg::CH_QUIT);
    send_esc(ekdc_pkg::CH_CSI, ekdc_pkg::CH_RIGHT);
    send_esc(ekdc_pkg::CH_CSI, ekdc_pkg::CH_DOWN);
    send_esc(ekdc_pkg::CH_SS3, ekdc_pkg::CH_END);
    send_esc(ekdc_pkg::CH_SS3, ekdc_pkg::CH_HOME);
    send_esc(ekdc_pkg::CH_CSI, ekdc_pkg::CH_DIG3);
    send_beat(1'b0, ekdc_pkg::CH_TILDE);
    send_esc(ekdc_pkg::CH_CSI, ekdc_pkg::CH_DIG6);
    send_beat(1'b0, ekdc_pkg::CH_TILDE);
    send_beat(1'b0, ekdc_pkg::CH_ESC);
    send_beat(1'b1, 8'hff);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin r = 10'd1023; c = 10'd1023; end
        1:       begin r = 10'd1;    c = 10'd1;    end
        2:       begin r = '0;       c = '0;       end
        3:       begin r = 10'd3;    c = 10'd5;    end
        default: begin r = pick_size(); c = pick_size(); end
      endcase
      write_sizes(r, c);
      gappy <= ($urandom_range(0, 3) != 0);
      if (p == 3) long_hold <= 1'b1;
      if (p == 4) long_hold <= 1'b0;
      if (p == N_PHASES - 1) calm <= 1'b1;
      start = beats_sent;
      while (beats_sent - start < PHASE_BEATS) send_random_key();
      settle();
    end

    if (n_fail == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: escape_key_decoder_cursor.f
src/ekdc_pkg.sv
src/ekdc_parser.sv
src/escape_key_decoder_cursor.sv
src/ekdc_checker.sv
tb/ekdc_key_checker.sv
tb/tb_top.sv
